[hw/rtl/lz77_pkg.sv]
// Shared types and constants for the LZ77 token decompressor.
package lz77_pkg;
	localparam int Window = 4096;
	localparam int Lanes = 8;
	localparam int AddrW = $clog2(Window);
	localparam int CntW = AddrW + 1;
	localparam int MaxLen = 258;
	localparam int LaneCntW = $clog2(Lanes + 1);

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_INVALID = 2'd1,
		ST_LIMIT = 2'd2,
		ST_TRUNC = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		PH_CODE = 2'd0,
		PH_LEN = 2'd1,
		PH_DIST = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_WAIT,
		S_EMIT,
		S_LIT,
		S_EOS
	} state_t;

	typedef struct packed {
		logic take;
		logic start_rd;
		logic step;
		logic load_lit;
		logic load_copy;
		logic load_eos;
		logic clear_stream;
	} cmd_t;

	typedef struct packed {
		logic in_valid;
		logic is_lit;
		logic is_copy;
		logic is_eos;
		logic lane_last;
		logic copy_last;
		logic out_busy;
	} sts_t;
endpackage

[hw/rtl/lz77_token_decompressor_core.sv]
// Top level of the LZ77 token decompressor.
// An item that is a literal, a skip or a code word is taken once the output register is
// free. The distance word of a match is taken the same way, and the copy then reads the
// history memory one byte at a time through S_RD and S_WAIT (registered RAM read) and loads
// each result of up to eight bytes in S_EMIT; the input is held until the copy is done. An
// end-of-stream status result after a literal or a copy is loaded from its own state, S_EOS;
// otherwise it leaves with its item. No item is taken while a result waits for
// out_ready. Bytes leave up to eight per result; an error is sticky until end of stream.
module lz77_token_decompressor_core (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [15:0] token_word,
	input  logic end_of_stream,
	output logic out_valid,
	input  logic out_ready,
	output logic [7:0] byte_0,
	output logic [7:0] byte_1,
	output logic [7:0] byte_2,
	output logic [7:0] byte_3,
	output logic [7:0] byte_4,
	output logic [7:0] byte_5,
	output logic [7:0] byte_6,
	output logic [7:0] byte_7,
	output logic [3:0] byte_count,
	output logic run_last,
	output logic stream_done,
	output logic [1:0] status
);
	import lz77_pkg::*;

	cmd_t cmd, cmd_g;
	sts_t sts_dp, sts;

	always_comb begin
		sts = sts_dp;
		sts.in_valid = in_valid;
		cmd_g = cmd;
	end
	assign in_ready = cmd.take;

	lz77_ctrl u_ctrl (.clk, .arst_n, .sts, .cmd);

	lz77_dp u_dp (
		.clk, .arst_n, .token_word, .end_of_stream, .cmd(cmd_g), .sts(sts_dp),
		.out_ready, .out_valid, .byte_0, .byte_1, .byte_2, .byte_3, .byte_4,
		.byte_5, .byte_6, .byte_7, .byte_count, .run_last, .stream_done, .status
	);
endmodule

[hw/rtl/lz77_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module lz77_ram #(
	parameter int Width = 8,
	parameter int Depth = 4096
) (
	input  logic clk,
	input  logic wr_en,
	input  logic [$clog2(Depth)-1:0] wr_addr,
	input  logic [Width-1:0] wr_data,
	input  logic [$clog2(Depth)-1:0] rd_addr,
	output logic [Width-1:0] rd_data
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_data <= mem[rd_addr];
	end
endmodule

[hw/rtl/lz77_ctrl.sv]
// Control state machine for the LZ77 token decompressor.
module lz77_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  lz77_pkg::sts_t sts,
	output lz77_pkg::cmd_t cmd
);
	import lz77_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	// An end-of-stream item with no data result leaves its status result at once,
	// so only a literal or a copy needs the separate status state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (sts.in_valid && !sts.out_busy) begin
					if (sts.is_copy) state_d = S_RD;
					else if (sts.is_lit) state_d = sts.is_eos ? S_EOS : S_IDLE;
				end
			end
			S_RD: state_d = S_WAIT;
			S_WAIT: begin
				if (sts.lane_last) state_d = S_EMIT;
				else state_d = S_RD;
			end
			S_EMIT: begin
				if (!sts.out_busy) begin
					if (!sts.copy_last) state_d = S_RD;
					else if (sts.is_eos) state_d = S_EOS;
					else state_d = S_IDLE;
				end
			end
			S_LIT: state_d = S_IDLE;
			S_EOS: if (!sts.out_busy) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (sts.in_valid && !sts.out_busy) begin
					cmd.take = 1'b1;
					cmd.load_lit = sts.is_lit;
				end
			end
			S_RD: cmd.start_rd = 1'b1;
			S_WAIT: cmd.step = 1'b1;
			S_EMIT: cmd.load_copy = !sts.out_busy;
			S_EOS: begin
				cmd.load_eos = !sts.out_busy;
				cmd.clear_stream = !sts.out_busy;
			end
			default: ;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RD |=> state_q == S_WAIT)
		else $error("read not followed by wait");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |-> state_q == S_IDLE)
		else $error("item taken while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		$countones({cmd.load_lit, cmd.load_copy, cmd.load_eos}) <= 1)
		else $error("two results loaded at once");
endmodule

[hw/rtl/lz77_dp.sv]
// Datapath for the LZ77 token decompressor: token decode, history, output register.
module lz77_dp (
	input  logic clk,
	input  logic arst_n,
	input  logic [15:0] token_word,
	input  logic end_of_stream,
	input  lz77_pkg::cmd_t cmd,
	output lz77_pkg::sts_t sts,
	input  logic out_ready,
	output logic out_valid,
	output logic [7:0] byte_0,
	output logic [7:0] byte_1,
	output logic [7:0] byte_2,
	output logic [7:0] byte_3,
	output logic [7:0] byte_4,
	output logic [7:0] byte_5,
	output logic [7:0] byte_6,
	output logic [7:0] byte_7,
	output logic [3:0] byte_count,
	output logic run_last,
	output logic stream_done,
	output logic [1:0] status
);
	import lz77_pkg::*;

	phase_t phase_q;
	logic [8:0] plen_q;
	logic [AddrW-1:0] wp_q;
	logic [CntW-1:0] bw_q;
	status_t err_q;
	logic eos_q;
	logic [AddrW-1:0] dist_q;
	logic [8:0] left_q;
	logic [LaneCntW-1:0] lane_q;
	logic [7:0] lane_b_q [Lanes];
	logic [7:0] ob_q [8];
	logic [3:0] ocnt_q;
	logic olast_q, odone_q, ovalid_q;
	status_t ost_q;

	logic [7:0] rd_data;
	logic wr_en;
	logic [7:0] wr_data;
	logic [AddrW-1:0] rd_addr;

	// Decode of the word at the input.
	logic active, w_lit, w_start, copy_ok;
	status_t merr;
	logic [8:0] len_clamp;
	always_comb begin
		active = (err_q == ST_OK);
		w_lit = active && phase_q == PH_CODE && token_word < 16'd256;
		w_start = active && phase_q == PH_CODE && token_word > 16'd256;
		len_clamp = (token_word > 16'd511) ? 9'd511 : token_word[8:0];
		merr = ST_OK;
		if (plen_q == '0 || token_word == '0) merr = ST_INVALID;
		else if (plen_q > 9'(MaxLen) || {1'b0, token_word} > 17'(Window)) merr = ST_LIMIT;
		else if ({1'b0, token_word} > 17'(bw_q)) merr = ST_INVALID;
		copy_ok = active && phase_q == PH_DIST && merr == ST_OK;
	end

	assign sts.in_valid = 1'b1;
	assign sts.is_lit = w_lit;
	assign sts.is_copy = copy_ok;
	assign sts.is_eos = cmd.take ? end_of_stream : eos_q;
	assign sts.lane_last = (left_q == 9'd1) || (lane_q == LaneCntW'(Lanes - 1));
	assign sts.copy_last = (left_q == '0);
	assign sts.out_busy = ovalid_q && !out_ready;

	assign rd_addr = wp_q - dist_q;
	assign wr_en = cmd.load_lit || cmd.step;
	assign wr_data = cmd.load_lit ? token_word[7:0] : rd_data;

	lz77_ram #(.Width(8), .Depth(Window)) u_hist (
		.clk, .wr_en, .wr_addr(wp_q), .wr_data, .rd_addr, .rd_data
	);

	logic [CntW-1:0] bw_inc;
	assign bw_inc = (bw_q < CntW'(Window)) ? bw_q + 1'b1 : bw_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CODE;
			plen_q <= '0;
			wp_q <= '0;
			bw_q <= '0;
			err_q <= ST_OK;
			eos_q <= 1'b0;
			dist_q <= '0;
			left_q <= '0;
			lane_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (ovalid_q && out_ready) ovalid_q <= 1'b0;
			if (wr_en) begin
				wp_q <= wp_q + 1'b1;
				bw_q <= bw_inc;
			end
			if (cmd.take) begin
				eos_q <= end_of_stream;
				if (active) begin
					unique case (phase_q)
						PH_CODE: if (w_start) phase_q <= PH_LEN;
						PH_LEN: begin
							plen_q <= len_clamp;
							phase_q <= PH_DIST;
						end
						default: begin
							phase_q <= PH_CODE;
							plen_q <= '0;
							err_q <= merr;
							// A distance of a whole window wraps to zero, which reads the
							// same slot modulo the window.
							dist_q <= token_word[AddrW-1:0];
							left_q <= plen_q;
							lane_q <= '0;
						end
					endcase
				end
				// Result for an end-of-stream item with no other result.
				if (end_of_stream && !w_lit && !copy_ok) begin
					ovalid_q <= 1'b1;
				end
			end
			if (cmd.step) begin
				left_q <= left_q - 1'b1;
				lane_q <= lane_q + 1'b1;
			end
			if (cmd.load_copy) lane_q <= '0;
			if (cmd.load_lit || cmd.load_copy || cmd.load_eos) ovalid_q <= 1'b1;
			if (cmd.clear_stream) begin
				phase_q <= PH_CODE;
				plen_q <= '0;
				wp_q <= '0;
				bw_q <= '0;
				err_q <= ST_OK;
				eos_q <= 1'b0;
			end
			// End-of-stream path when the item gives no data: the stream state is cleared as it is taken.
			if (cmd.take && end_of_stream && !w_lit && !copy_ok) begin
				phase_q <= PH_CODE;
				plen_q <= '0;
				wp_q <= '0;
				bw_q <= '0;
				err_q <= ST_OK;
				eos_q <= 1'b0;
			end
		end
	end

	// Final status for an end-of-stream item that gives no data.
	status_t eos_now;
	always_comb begin
		eos_now = err_q;
		if (active && phase_q == PH_DIST) eos_now = merr;
		if (eos_now == ST_OK && active &&
			(phase_q == PH_LEN || (phase_q == PH_CODE && w_start)))
			eos_now = ST_TRUNC;
	end

	always_ff @(posedge clk) begin
		if (cmd.step) lane_b_q[lane_q[$clog2(Lanes)-1:0]] <= rd_data;
		if (cmd.take && end_of_stream && !w_lit && !copy_ok) begin
			for (int i = 0; i < 8; i++) ob_q[i] <= '0;
			ocnt_q <= '0;
			olast_q <= 1'b1;
			odone_q <= 1'b1;
			ost_q <= eos_now;
		end
		if (cmd.load_lit) begin
			for (int i = 0; i < 8; i++) ob_q[i] <= (i == 0) ? token_word[7:0] : 8'd0;
			ocnt_q <= 4'd1;
			olast_q <= !end_of_stream;
			odone_q <= 1'b0;
			ost_q <= ST_OK;
		end
		if (cmd.load_copy) begin
			for (int i = 0; i < 8; i++) begin
				ob_q[i] <= (i < Lanes && 4'(i) < 4'(lane_q)) ?
					lane_b_q[i % Lanes] : 8'd0;
			end
			ocnt_q <= 4'(lane_q);
			olast_q <= sts.copy_last && !eos_q;
			odone_q <= 1'b0;
			ost_q <= ST_OK;
		end
		if (cmd.load_eos) begin
			for (int i = 0; i < 8; i++) ob_q[i] <= '0;
			ocnt_q <= '0;
			olast_q <= 1'b1;
			odone_q <= 1'b1;
			ost_q <= err_q;
		end
	end

	// lane_q holds the number of bytes gathered for the result being built.
	assign out_valid = ovalid_q;
	assign byte_0 = ob_q[0];
	assign byte_1 = ob_q[1];
	assign byte_2 = ob_q[2];
	assign byte_3 = ob_q[3];
	assign byte_4 = ob_q[4];
	assign byte_5 = ob_q[5];
	assign byte_6 = ob_q[6];
	assign byte_7 = ob_q[7];
	assign byte_count = ocnt_q;
	assign run_last = olast_q;
	assign stream_done = odone_q;
	assign status = ost_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stream_done |-> byte_count == '0)
		else $error("status result carries data");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !stream_done |-> status == ST_OK)
		else $error("data result with error status");
	assert property (@(posedge clk) disable iff (!arst_n)
		bw_q <= CntW'(Window))
		else $error("byte count beyond window");
endmodule
